// ----- hdl/lzwc_pkg.sv -----
// Shared types and constants of the LZW compressor.
`default_nettype none

package lzwc_pkg;

    localparam int SYMBOL_W      = 7;
    localparam int CODE_W        = 12;
    localparam int FIRST_LEARNED = 128;
    localparam int EPOCH_BITS    = 8;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              final_code;
    } t_out_word;

    // write request from the sequencer to the dictionary table
    typedef struct packed {
        logic wr_en;
        logic clear;
    } t_dict_ctl;

    // outcome of one probe of the table
    typedef struct packed {
        logic occupied;
        logic hit;
    } t_probe;

endpackage

`default_nettype wire

// ----- hdl/lzw_compressor.sv -----
// LZW compressor top level: sequencer, prefix state and output word register.
`default_nettype none

// LZW compressor. Each input word carries one 7-bit character and an end-of-message
// flag; output words carry a 12-bit code and a flag on the last code of a message.
// The dictionary is an open-addressed hash table of 2^(CODE_BITS+1) slots held in one
// single-port memory, probed one slot at a time (one read plus one compare per probe).
// Each input word is finished before the next one is taken; a new pair also waits
// until the output register is free. The table is at most half full, so probe chains
// stay short. Old messages are retired by an epoch tag per slot; after reset, and
// after every 255th message, a clearing pass over all slots runs before the next word
// is taken.
module lzw_compressor
    import lzwc_pkg::*;
#(
    parameter int CODE_BITS = 12
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    localparam int SLOT_BITS = CODE_BITS + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_CLEAR = 3'd5;

    logic [2:0]            r_state,     n_state;
    logic [CODE_BITS-1:0]  r_cur,       n_cur;
    logic                  r_have,      n_have;
    logic [CODE_BITS:0]    r_next_free, n_next_free;
    logic [SYMBOL_W-1:0]   r_ch,        n_ch;
    logic                  r_eom,       n_eom;
    logic [SLOT_BITS-1:0]  r_slot,      n_slot;
    logic [SLOT_BITS-1:0]  r_clr,       n_clr;
    logic [EPOCH_BITS-1:0] r_epoch,     n_epoch;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out_word,  n_out_word;

    t_dict_ctl             w_ctl;
    t_probe                w_probe;
    logic [CODE_BITS-1:0]  w_code;
    logic [SLOT_BITS-1:0]  w_home;
    logic [SLOT_BITS-1:0]  w_addr;
    logic                  w_out_free;
    logic                  w_accept;

    // home slot: character folded into the top bits of the prefix code
    assign w_home = (SLOT_BITS'(i_in_word.symbol) << (SLOT_BITS - SYMBOL_W))
                    ^ SLOT_BITS'(r_cur);
    assign w_addr = (r_state == S_CLEAR) ? r_clr : r_slot;

    lzwc_dict #(
        .CODE_BITS (CODE_BITS)
    ) u_dict (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_addr       (w_addr),
        .i_epoch      (r_epoch),
        .i_key_prefix (r_cur),
        .i_key_symbol (r_ch),
        .i_wr_code    (r_next_free[CODE_BITS-1:0]),
        .o_probe      (w_probe),
        .o_code       (w_code)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_have      = r_have;
        n_next_free = r_next_free;
        n_ch        = r_ch;
        n_eom       = r_eom;
        n_slot      = r_slot;
        n_clr       = r_clr;
        n_epoch     = r_epoch;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        w_ctl       = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ch  = i_in_word.symbol;
                    n_eom = i_in_word.end_of_message;
                    if (!r_have) begin
                        n_cur   = CODE_BITS'(i_in_word.symbol);
                        n_have  = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_slot  = w_home;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_probe.hit) begin
                    n_cur   = w_code;
                    n_state = S_FIN;
                end else if (w_probe.occupied) begin
                    n_slot  = r_slot + 1'b1;
                    n_state = S_READ;
                end else begin
                    // new pair: learn it in this empty slot while there is room
                    if (!r_next_free[CODE_BITS]) begin
                        w_ctl.wr_en = 1'b1;
                        n_next_free = r_next_free + 1'b1;
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_word.code       = CODE_W'(r_cur);
                    n_out_word.final_code = 1'b0;
                    n_cur                 = CODE_BITS'(r_ch);
                    n_state               = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_eom) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_word.code       = CODE_W'(r_cur);
                    n_out_word.final_code = 1'b1;
                    n_cur                 = '0;
                    n_have                = 1'b0;
                    n_next_free           = (CODE_BITS + 1)'(FIRST_LEARNED);
                    if (r_epoch == '1) begin
                        n_epoch = EPOCH_BITS'(1);
                        n_state = S_CLEAR;
                    end else begin
                        n_epoch = r_epoch + 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_CLEAR: begin
                w_ctl.wr_en = 1'b1;
                w_ctl.clear = 1'b1;
                n_clr       = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cur       <= '0;
            r_have      <= 1'b0;
            r_next_free <= (CODE_BITS + 1)'(FIRST_LEARNED);
            r_eom       <= 1'b0;
            r_clr       <= '0;
            r_epoch     <= EPOCH_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_have      <= n_have;
            r_next_free <= n_next_free;
            r_eom       <= n_eom;
            r_clr       <= n_clr;
            r_epoch     <= n_epoch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch       <= n_ch;
        r_slot     <= n_slot;
        r_out_word <= n_out_word;
    end

`ifndef SYNTHESIS
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= (CODE_BITS + 1)'(2 ** CODE_BITS))
        else $error("next free code beyond dictionary size");

    a_fresh_dict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> r_next_free == (CODE_BITS + 1)'(FIRST_LEARNED))
        else $error("dictionary holds entries without a pending prefix");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("live epoch equals the cleared slot tag");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_eom && w_out_free) |=>
            (r_out_valid && r_out_word.final_code && !r_have))
        else $error("final word issued without clearing the prefix");
`endif

endmodule

`default_nettype wire

// ----- hdl/lzwc_dict.sv -----
// Hashed dictionary table: slot memory with epoch tags and the probe compare.
`default_nettype none

module lzwc_dict
    import lzwc_pkg::*;
#(
    parameter int CODE_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire t_dict_ctl                     i_ctl,
    input  wire logic [CODE_BITS:0]            i_addr,
    input  wire logic [EPOCH_BITS-1:0]         i_epoch,
    input  wire logic [CODE_BITS-1:0]          i_key_prefix,
    input  wire logic [SYMBOL_W-1:0]           i_key_symbol,
    input  wire logic [CODE_BITS-1:0]          i_wr_code,
    output t_probe                             o_probe,
    output logic [CODE_BITS-1:0]               o_code
);

    localparam int SLOTS = 2 ** (CODE_BITS + 1);

    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        logic [CODE_BITS-1:0]  prefix;
        logic [SYMBOL_W-1:0]   symbol;
        logic [CODE_BITS-1:0]  code;
    } t_slot;

    t_slot mem [SLOTS];
    t_slot r_rd;
    t_slot w_wr;

    always_comb begin
        w_wr.epoch  = i_ctl.clear ? '0 : i_epoch;
        w_wr.prefix = i_key_prefix;
        w_wr.symbol = i_key_symbol;
        w_wr.code   = i_wr_code;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_addr] <= w_wr;
        end
        r_rd <= mem[i_addr];
    end

    // a slot from an older message carries a stale epoch and counts as empty
    always_comb begin
        o_probe.occupied = (r_rd.epoch == i_epoch);
        o_probe.hit      = o_probe.occupied && (r_rd.prefix == i_key_prefix)
                           && (r_rd.symbol == i_key_symbol);
        o_code           = r_rd.code;
    end

endmodule

`default_nettype wire
